/* rtl/uctbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uctbs_pkg - shared types and constants
// Register map, tone constants, UTF-8 lead masks and the structs passed
// between the decoder, the divider, the register file and the sequencer.
// ----------------------------------------------------------------------------
package uctbs_pkg;

    // Shared divider geometry
    localparam int DIV_W  = 27;
    localparam int DVS_W  = 15;
    localparam int CNT_W  = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_AMPLITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_TIME_MS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME_MS    = 2'd3;

    // Register bounds and reset values
    localparam logic [14:0] RATE_MIN = 15'd8000;
    localparam logic [14:0] RATE_MAX = 15'd24000;
    localparam logic [14:0] RATE_RST = 15'd16000;
    localparam logic [13:0] AMP_MIN  = 14'd512;
    localparam logic [13:0] AMP_MAX  = 14'd16000;
    localparam logic [13:0] AMP_RST  = 14'd9000;
    localparam logic [7:0]  CHAR_MIN = 8'd20;
    localparam logic [7:0]  CHAR_MAX = 8'd240;
    localparam logic [7:0]  CHAR_RST = 8'd120;
    localparam logic [6:0]  GAP_MAX  = 7'd80;
    localparam logic [6:0]  GAP_RST  = 7'd20;

    // Tone constants
    localparam logic [8:0]       FREQ_BASE = 9'd170;
    localparam logic [DVS_W-1:0] FREQ_MOD  = 15'd260;
    localparam logic [DVS_W-1:0] BUZZ_MOD  = 15'd17;
    localparam logic [4:0]       BUZZ_OFS  = 5'd3;
    localparam logic [5:0]       BUZZ_BASE = 6'd24;
    localparam logic [DVS_W-1:0] SHAPE_DIV = 15'd40;
    localparam logic [DVS_W-1:0] MS_PER_S  = 15'd1000;

    // UTF-8 lead byte classes
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    // Whitespace characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic [14:0] sample_rate;
        logic [13:0] peak_amplitude;
        logic [7:0]  char_time_ms;
        logic [6:0]  gap_time_ms;
    } cfg_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  bytes_used;
        logic        is_space;
    } dec_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/uctbs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uctbs_if - command and result channels
// Valid/ready channels carrying one command and one result per transaction.
// ----------------------------------------------------------------------------
interface uctbs_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;

    modport source (output valid, command, byte0, byte1, byte2, byte3, input ready);
    modport sink   (input valid, command, byte0, byte1, byte2, byte3, output ready);
endinterface

interface uctbs_rsp_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [2:0]         bytes_used;
    logic [20:0]        code_point;
    logic [12:0]        token_samples;
    logic signed [15:0] pcm_sample;
    logic               last;
    logic               active;

    modport source (output valid, accepted, bytes_used, code_point, token_samples,
                    pcm_sample, last, active, input ready);
    modport sink   (input valid, accepted, bytes_used, code_point, token_samples,
                    pcm_sample, last, active, output ready);
endinterface

/* rtl/uctbs_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uctbs_cfg - setting registers
// Four write-only registers, each clamped into its legal range on write.
// ----------------------------------------------------------------------------
module uctbs_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [uctbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uctbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output uctbs_pkg::cfg_t                cfg
);
    import uctbs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SAMPLE_RATE:
                begin
                    if (cfg_wdata[14:0] < RATE_MIN)
                        cfg_next.sample_rate = RATE_MIN;
                    else if (cfg_wdata[14:0] > RATE_MAX)
                        cfg_next.sample_rate = RATE_MAX;
                    else
                        cfg_next.sample_rate = cfg_wdata[14:0];
                end
                CFG_PEAK_AMPLITUDE:
                begin
                    if (cfg_wdata[13:0] < AMP_MIN)
                        cfg_next.peak_amplitude = AMP_MIN;
                    else if (cfg_wdata[13:0] > AMP_MAX)
                        cfg_next.peak_amplitude = AMP_MAX;
                    else
                        cfg_next.peak_amplitude = cfg_wdata[13:0];
                end
                CFG_CHAR_TIME_MS:
                begin
                    if (cfg_wdata[7:0] < CHAR_MIN)
                        cfg_next.char_time_ms = CHAR_MIN;
                    else if (cfg_wdata[7:0] > CHAR_MAX)
                        cfg_next.char_time_ms = CHAR_MAX;
                    else
                        cfg_next.char_time_ms = cfg_wdata[7:0];
                end
                CFG_GAP_TIME_MS:
                begin
                    if (cfg_wdata[6:0] > GAP_MAX)
                        cfg_next.gap_time_ms = GAP_MAX;
                    else
                        cfg_next.gap_time_ms = cfg_wdata[6:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_rate    <= RATE_RST;
            cfg_reg.peak_amplitude <= AMP_RST;
            cfg_reg.char_time_ms   <= CHAR_RST;
            cfg_reg.gap_time_ms    <= GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/uctbs_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uctbs_decode - UTF-8 token decoder
// Decodes one token from four bytes; a malformed sequence yields its lead byte.
// ----------------------------------------------------------------------------
module uctbs_decode (
    input  logic [7:0]      byte0,
    input  logic [7:0]      byte1,
    input  logic [7:0]      byte2,
    input  logic [7:0]      byte3,
    output uctbs_pkg::dec_t dec
);
    import uctbs_pkg::*;

    logic c1;
    logic c2;
    logic c3;

    assign c1 = (byte1[7:6] == CONT_TAG);
    assign c2 = (byte2[7:6] == CONT_TAG);
    assign c3 = (byte3[7:6] == CONT_TAG);

    always_comb
    begin
        dec.code_point = {13'd0, byte0};
        dec.bytes_used = 3'd1;
        if (byte0[7])
        begin
            if (((byte0 & LEAD2_MASK) == LEAD2_CODE) && c1)
            begin
                dec.code_point = {10'd0, byte0[4:0], byte1[5:0]};
                dec.bytes_used = 3'd2;
            end
            else if (((byte0 & LEAD3_MASK) == LEAD3_CODE) && c1 && c2)
            begin
                dec.code_point = {5'd0, byte0[3:0], byte1[5:0], byte2[5:0]};
                dec.bytes_used = 3'd3;
            end
            else if (((byte0 & LEAD4_MASK) == LEAD4_CODE) && c1 && c2 && c3)
            begin
                dec.code_point = {byte0[2:0], byte1[5:0], byte2[5:0], byte3[5:0]};
                dec.bytes_used = 3'd4;
            end
        end
        dec.is_space = (byte0 == CH_SPACE) || (byte0 == CH_LF) ||
                       (byte0 == CH_CR) || (byte0 == CH_TAB);
    end

endmodule

/* rtl/uctbs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uctbs_div - shared restoring divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module uctbs_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [uctbs_pkg::DIV_W-1:0]  dividend,
    input  logic [uctbs_pkg::DVS_W-1:0]  divisor,
    output logic [uctbs_pkg::DIV_W-1:0]  quotient,
    output logic [uctbs_pkg::DVS_W-1:0]  remainder,
    output uctbs_pkg::div_stat_t         stat
);
    import uctbs_pkg::*;

    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign quotient   = quo_reg;
    assign remainder  = rem_reg;
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;

endmodule

/* rtl/utf8_character_buzz_tone_synth.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_character_buzz_tone_synth - UTF-8 character buzz tone synthesiser
// Decodes text tokens and plays each as a faded square buzz tone plus silence.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and each gives one result. All division
// runs through a single restoring divider that delivers one quotient bit per
// cycle, under a small sequencer. A character command costs four divisions
// (code point mod 260, mod 17, tone length and gap length), or three for a
// blank token, which has no tone length to divide. A tick inside the tone
// costs three divisions (phase, fade envelope, buzz shaping), or two outside
// the fades. A tick during the gap or while idle, and a refused character
// command, need no division. The next command is taken once the previous
// result sits in the output register, even if it has not yet been collected.
// Token lengths are latched when a character is taken; phase and amplitude
// follow the settings present at each tick.
// ----------------------------------------------------------------------------
module utf8_character_buzz_tone_synth (
    input  logic                            clk,
    input  logic                            rst_n,
    uctbs_req_if.sink                       request,
    uctbs_rsp_if.source                     response,
    input  logic                            cfg_wr_en,
    input  logic [uctbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uctbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import uctbs_pkg::*;

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_MOD260 = 4'd2;
    localparam logic [3:0] ST_MOD17  = 4'd3;
    localparam logic [3:0] ST_TONE   = 4'd4;
    localparam logic [3:0] ST_GAP    = 4'd5;
    localparam logic [3:0] ST_PHASE  = 4'd6;
    localparam logic [3:0] ST_ENV    = 4'd7;
    localparam logic [3:0] ST_SHAPE  = 4'd8;
    localparam logic [3:0] ST_STEP   = 4'd9;
    localparam logic [3:0] ST_FINISH = 4'd10;

    // Dividend sources
    localparam logic [1:0] DVD_CODE = 2'd0;
    localparam logic [1:0] DVD_MUL  = 2'd1;
    localparam logic [1:0] DVD_MUL2 = 2'd2;

    cfg_t      cfg;
    dec_t      dec;
    div_stat_t div_stat;

    logic             div_start;
    logic [1:0]       dvd_sel;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_q;
    logic [DVS_W-1:0] div_r;

    logic [14:0] mul_a;
    logic [12:0] mul_b;
    logic [27:0] mul_p;

    // Sequencer and token state
    logic [3:0]  state_reg,        state_next;
    logic [20:0] current_code_reg, current_code_next;
    logic        is_space_reg,     is_space_next;
    logic [12:0] position_reg,     position_next;
    logic        playing_reg,      playing_next;
    logic [12:0] tone_length_reg,  tone_length_next;
    logic [10:0] gap_length_reg,   gap_length_next;

    // Captured command
    logic        cmd_reg,   cmd_next;
    logic [7:0]  b0_reg,    b0_next;
    logic [7:0]  b1_reg,    b1_next;
    logic [7:0]  b2_reg,    b2_next;
    logic [7:0]  b3_reg,    b3_next;

    // Working registers
    logic [2:0]  used_reg,      used_next;
    logic [8:0]  freq_reg,      freq_next;
    logic [4:0]  buzz_mul_reg,  buzz_mul_next;
    logic [4:0]  buzz_reg,      buzz_next;
    logic        phase_odd_reg, phase_odd_next;
    logic [15:0] sample_reg,    sample_next;

    // Staged result
    logic        res_accepted_reg, res_accepted_next;
    logic [2:0]  res_used_reg,     res_used_next;
    logic [20:0] res_code_reg,     res_code_next;
    logic [12:0] res_samples_reg,  res_samples_next;
    logic [15:0] res_pcm_reg,      res_pcm_next;
    logic        res_last_reg,     res_last_next;
    logic        res_active_reg,   res_active_next;

    // Output register
    logic        out_valid_reg,    out_valid_next;
    logic        out_accepted_reg, out_accepted_next;
    logic [2:0]  out_used_reg,     out_used_next;
    logic [20:0] out_code_reg,     out_code_next;
    logic [12:0] out_samples_reg,  out_samples_next;
    logic [15:0] out_pcm_reg,      out_pcm_next;
    logic        out_last_reg,     out_last_next;
    logic        out_active_reg,   out_active_next;

    // Derived token quantities
    logic [9:0]  fade;
    logic        fade_nz;
    logic        fade_in;
    logic        fade_out;
    logic        in_tone;
    logic [13:0] total_len;
    logic [13:0] pos_inc;
    logic [13:0] new_total;
    logic [9:0]  buzz_prod;
    logic [15:0] shaped;

    uctbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    uctbs_decode u_decode (
        .byte0 (b0_reg),
        .byte1 (b1_reg),
        .byte2 (b2_reg),
        .byte3 (b3_reg),
        .dec   (dec)
    );

    uctbs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    // Single multiplier; its product is registered in the divider
    assign mul_p = {13'd0, mul_a} * {15'd0, mul_b};

    always_comb
    begin
        case (dvd_sel)
            DVD_CODE: div_dividend = {6'd0, current_code_next};
            DVD_MUL:  div_dividend = mul_p[DIV_W-1:0];
            DVD_MUL2: div_dividend = {mul_p[DIV_W-2:0], 1'b0};
            default:  div_dividend = mul_p[DIV_W-1:0];
        endcase
    end

    // Fade is one eighth of the tone
    assign fade      = tone_length_reg[12:3];
    assign fade_nz   = (fade != 10'd0);
    assign fade_in   = fade_nz && ({3'd0, fade} > position_reg);
    assign fade_out  = fade_nz &&
                       (({1'b0, position_reg} + {4'd0, fade}) >= {1'b0, tone_length_reg});
    assign in_tone   = !is_space_reg && (position_reg < tone_length_reg);
    assign total_len = {1'b0, tone_length_reg} + {3'd0, gap_length_reg};
    assign pos_inc   = {1'b0, position_reg} + 14'd1;
    assign new_total = {1'b0, tone_length_reg} + {3'd0, div_q[10:0]};
    assign buzz_prod = {5'd0, position_reg[4:0]} * {5'd0, buzz_mul_reg};
    assign shaped    = div_q[15:0];

    always_comb
    begin
        state_next        = state_reg;
        current_code_next = current_code_reg;
        is_space_next     = is_space_reg;
        position_next     = position_reg;
        playing_next      = playing_reg;
        tone_length_next  = tone_length_reg;
        gap_length_next   = gap_length_reg;
        cmd_next          = cmd_reg;
        b0_next           = b0_reg;
        b1_next           = b1_reg;
        b2_next           = b2_reg;
        b3_next           = b3_reg;
        used_next         = used_reg;
        freq_next         = freq_reg;
        buzz_mul_next     = buzz_mul_reg;
        buzz_next         = buzz_reg;
        phase_odd_next    = phase_odd_reg;
        sample_next       = sample_reg;
        res_accepted_next = res_accepted_reg;
        res_used_next     = res_used_reg;
        res_code_next     = res_code_reg;
        res_samples_next  = res_samples_reg;
        res_pcm_next      = res_pcm_reg;
        res_last_next     = res_last_reg;
        res_active_next   = res_active_reg;
        out_accepted_next = out_accepted_reg;
        out_used_next     = out_used_reg;
        out_code_next     = out_code_reg;
        out_samples_next  = out_samples_reg;
        out_pcm_next      = out_pcm_reg;
        out_last_next     = out_last_reg;
        out_active_next   = out_active_reg;
        div_start         = 1'b0;
        dvd_sel           = DVD_MUL;
        div_divisor       = MS_PER_S;
        mul_a             = '0;
        mul_b             = '0;

        // Drop the held result once the consumer takes it
        out_valid_next = out_valid_reg && !response.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    cmd_next   = request.command;
                    b0_next    = request.byte0;
                    b1_next    = request.byte1;
                    b2_next    = request.byte2;
                    b3_next    = request.byte3;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                res_accepted_next = 1'b0;
                res_used_next     = 3'd0;
                res_code_next     = 21'd0;
                res_samples_next  = 13'd0;
                res_pcm_next      = 16'd0;
                res_last_next     = 1'b0;
                res_active_next   = playing_reg;
                if (!cmd_reg)
                begin
                    if (playing_reg || (b0_reg == 8'd0))
                    begin
                        // Busy or end of text: refuse
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        current_code_next = dec.code_point;
                        is_space_next     = dec.is_space;
                        used_next         = dec.bytes_used;
                        div_start         = 1'b1;
                        dvd_sel           = DVD_CODE;
                        div_divisor       = FREQ_MOD;
                        state_next        = ST_MOD260;
                    end
                end
                else if (!playing_reg)
                begin
                    // Idle tick
                    state_next = ST_FINISH;
                end
                else if (in_tone)
                begin
                    buzz_next   = buzz_prod[4:0];
                    mul_a       = {2'd0, position_reg};
                    mul_b       = {4'd0, freq_reg};
                    div_start   = 1'b1;
                    dvd_sel     = DVD_MUL2;
                    div_divisor = cfg.sample_rate;
                    state_next  = ST_PHASE;
                end
                else
                begin
                    sample_next = 16'd0;
                    state_next  = ST_STEP;
                end
            end

            ST_MOD260:
            begin
                if (div_stat.done)
                begin
                    freq_next   = FREQ_BASE + div_r[8:0];
                    div_start   = 1'b1;
                    dvd_sel     = DVD_CODE;
                    div_divisor = BUZZ_MOD;
                    state_next  = ST_MOD17;
                end
            end

            ST_MOD17:
            begin
                if (div_stat.done)
                begin
                    buzz_mul_next = div_r[4:0] + BUZZ_OFS;
                    mul_a         = cfg.sample_rate;
                    div_start     = 1'b1;
                    if (is_space_reg)
                    begin
                        tone_length_next = 13'd0;
                        mul_b            = {6'd0, cfg.gap_time_ms};
                        state_next       = ST_GAP;
                    end
                    else
                    begin
                        mul_b      = {5'd0, cfg.char_time_ms};
                        state_next = ST_TONE;
                    end
                end
            end

            ST_TONE:
            begin
                if (div_stat.done)
                begin
                    tone_length_next = div_q[12:0];
                    mul_a            = cfg.sample_rate;
                    mul_b            = {6'd0, cfg.gap_time_ms};
                    div_start        = 1'b1;
                    state_next       = ST_GAP;
                end
            end

            ST_GAP:
            begin
                if (div_stat.done)
                begin
                    gap_length_next   = div_q[10:0];
                    position_next     = 13'd0;
                    playing_next      = (new_total != 14'd0);
                    res_accepted_next = 1'b1;
                    res_used_next     = used_reg;
                    res_code_next     = current_code_reg;
                    res_samples_next  = new_total[12:0];
                    res_active_next   = (new_total != 14'd0);
                    state_next        = ST_FINISH;
                end
            end

            ST_PHASE:
            begin
                if (div_stat.done)
                begin
                    phase_odd_next = div_q[0];
                    div_start      = 1'b1;
                    mul_a          = {1'b0, cfg.peak_amplitude};
                    if (fade_in)
                    begin
                        mul_b       = position_reg;
                        div_divisor = {5'd0, fade};
                        state_next  = ST_ENV;
                    end
                    else if (fade_out)
                    begin
                        mul_b       = tone_length_reg - position_reg;
                        div_divisor = {5'd0, fade};
                        state_next  = ST_ENV;
                    end
                    else
                    begin
                        // Flat part: shape the peak directly
                        mul_b       = {7'd0, BUZZ_BASE + {1'b0, buzz_reg}};
                        div_divisor = SHAPE_DIV;
                        state_next  = ST_SHAPE;
                    end
                end
            end

            ST_ENV:
            begin
                if (div_stat.done)
                begin
                    mul_a       = div_q[14:0];
                    mul_b       = {7'd0, BUZZ_BASE + {1'b0, buzz_reg}};
                    div_start   = 1'b1;
                    div_divisor = SHAPE_DIV;
                    state_next  = ST_SHAPE;
                end
            end

            ST_SHAPE:
            begin
                if (div_stat.done)
                begin
                    sample_next = phase_odd_reg ? (16'd0 - shaped) : shaped;
                    state_next  = ST_STEP;
                end
            end

            ST_STEP:
            begin
                // Advance the play position and detect the token's end
                res_pcm_next = sample_reg;
                if (pos_inc >= total_len)
                begin
                    res_last_next   = 1'b1;
                    res_active_next = 1'b0;
                    playing_next    = 1'b0;
                    position_next   = 13'd0;
                end
                else
                begin
                    res_last_next   = 1'b0;
                    res_active_next = 1'b1;
                    position_next   = pos_inc[12:0];
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_accepted_next = res_accepted_reg;
                    out_used_next     = res_used_reg;
                    out_code_next     = res_code_reg;
                    out_samples_next  = res_samples_reg;
                    out_pcm_next      = res_pcm_reg;
                    out_last_next     = res_last_reg;
                    out_active_next   = res_active_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            current_code_reg <= '0;
            is_space_reg     <= 1'b0;
            position_reg     <= '0;
            playing_reg      <= 1'b0;
            tone_length_reg  <= '0;
            gap_length_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            current_code_reg <= current_code_next;
            is_space_reg     <= is_space_next;
            position_reg     <= position_next;
            playing_reg      <= playing_next;
            tone_length_reg  <= tone_length_next;
            gap_length_reg   <= gap_length_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        b0_reg           <= b0_next;
        b1_reg           <= b1_next;
        b2_reg           <= b2_next;
        b3_reg           <= b3_next;
        used_reg         <= used_next;
        freq_reg         <= freq_next;
        buzz_mul_reg     <= buzz_mul_next;
        buzz_reg         <= buzz_next;
        phase_odd_reg    <= phase_odd_next;
        sample_reg       <= sample_next;
        res_accepted_reg <= res_accepted_next;
        res_used_reg     <= res_used_next;
        res_code_reg     <= res_code_next;
        res_samples_reg  <= res_samples_next;
        res_pcm_reg      <= res_pcm_next;
        res_last_reg     <= res_last_next;
        res_active_reg   <= res_active_next;
        out_accepted_reg <= out_accepted_next;
        out_used_reg     <= out_used_next;
        out_code_reg     <= out_code_next;
        out_samples_reg  <= out_samples_next;
        out_pcm_reg      <= out_pcm_next;
        out_last_reg     <= out_last_next;
        out_active_reg   <= out_active_next;
    end

    // Channel ports
    assign request.ready          = (state_reg == ST_IDLE);
    assign response.valid         = out_valid_reg;
    assign response.accepted      = out_accepted_reg;
    assign response.bytes_used    = out_used_reg;
    assign response.code_point    = out_code_reg;
    assign response.token_samples = out_samples_reg;
    assign response.pcm_sample    = out_pcm_reg;
    assign response.last          = out_last_reg;
    assign response.active        = out_active_reg;

`ifndef SYNTH
    // The final sample of a token never reports the token as still playing
    a_last_not_active: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> !(response.last && response.active))
        else $error("last and active both set on a result");

    // The play position stays inside the latched token length
    a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg |-> ({1'b0, position_reg} < total_len))
        else $error("play position beyond token length");

    // The divider is never restarted while a division is in flight
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A taken command closes the input until its result is in the output register
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("second command taken while one is in progress");
`endif

endmodule

/* tb/sv/tb_utf8_character_buzz_tone_synth.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_character_buzz_tone_synth - buzz tone synthesiser regression
// Drives character and tick commands into the synthesiser and checks every
// result field against a cycle-free behavioural model kept in the bench. It
// covers decoding, playout, fades, refusal while busy, settings saturation
// and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_utf8_character_buzz_tone_synth;

    import uctbs_pkg::*;

    // Command encoding on the request channel
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Cycles to let pass once the last result is in, before touching settings
    localparam int DRAIN_SETTLE = 8;
    // Quiet cycles at the very end, to catch any stray result
    localparam int END_SETTLE   = 40;
    // Length of the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;
    // Cycles without any transaction before the run is declared hung: the
    // hold-off plus a full three-division tick plus random idling, with margin
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  bytes_used;
        logic [20:0] code_point;
        logic [12:0] token_samples;
        logic [15:0] pcm_sample;
        logic        last;
        logic        active;
    } synth_out_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    uctbs_req_if req_ch ();
    uctbs_rsp_if rsp_ch ();

    utf8_character_buzz_tone_synth i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_ch),
        .response  (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Model state: settings as the block holds them, and the token in play
    // ------------------------------------------------------------------------
    logic [14:0] set_rate    = RATE_RST;
    logic [13:0] set_amp     = AMP_RST;
    logic [7:0]  set_char_ms = CHAR_RST;
    logic [6:0]  set_gap_ms  = GAP_RST;

    logic [20:0] tone_code     = '0;
    logic        tone_is_blank = 1'b0;
    logic [12:0] play_pos      = '0;
    logic        play_on       = 1'b0;
    logic [12:0] tone_len      = '0;
    logic [10:0] gap_len       = '0;

    // Results owed by the block, oldest first
    synth_out_t synth_out_due[$];

    // Shared control between the stimulus and the result side
    bit gaps_on       = 1'b1;
    bit stall_request = 1'b0;
    int stall_left    = 0;

    // Run statistics
    int n_errors  = 0;
    int n_sent    = 0;
    int n_results = 0;
    int n_tokens  = 0;
    int n_refused = 0;
    int n_tone    = 0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model functions
    // ------------------------------------------------------------------------
    function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One tone sample at position idx, using the settings of this moment
    function automatic logic [15:0] buzz_sample(input int unsigned idx);
        int unsigned code, freq, phase, env, fade, buzz, shaped;
        code  = tone_code;
        freq  = FREQ_BASE + code % FREQ_MOD;
        phase = idx * freq * 2 / set_rate;
        env   = set_amp;
        fade  = tone_len / 8;
        // Linear ramp up over the first eighth, down over the last eighth
        if (fade > 0 && idx < fade)
            env = env * idx / fade;
        else if (fade > 0 && idx + fade >= tone_len)
            env = env * (tone_len - idx) / fade;
        buzz   = (idx * (code % BUZZ_MOD + BUZZ_OFS)) & 32'h1F;
        shaped = env * (BUZZ_BASE + buzz) / SHAPE_DIV;
        return phase[0] ? 16'(0 - shaped) : 16'(shaped);
    endfunction

    // Work out the result of one accepted command and advance the model
    function automatic synth_out_t predict_synth(input logic cmd, input logic [31:0] text);
        synth_out_t  r;
        logic [7:0]  b0, b1, b2, b3;
        int unsigned cp, used, total;
        r  = '0;
        b0 = text[7:0];
        b1 = text[15:8];
        b2 = text[23:16];
        b3 = text[31:24];
        if (cmd == CMD_CHAR) begin
            // Busy, or end of text: refuse and report only the activity flag
            if (play_on || b0 == 8'h00) begin
                r.active = play_on;
                n_refused++;
                return r;
            end
            cp   = b0;
            used = 1;
            if (b0[7]) begin
                if ((b0 & LEAD2_MASK) == LEAD2_CODE && b1[7:6] == CONT_TAG) begin
                    cp   = {b0[4:0], b1[5:0]};
                    used = 2;
                end
                else if ((b0 & LEAD3_MASK) == LEAD3_CODE && b1[7:6] == CONT_TAG &&
                         b2[7:6] == CONT_TAG) begin
                    cp   = {b0[3:0], b1[5:0], b2[5:0]};
                    used = 3;
                end
                else if ((b0 & LEAD4_MASK) == LEAD4_CODE && b1[7:6] == CONT_TAG &&
                         b2[7:6] == CONT_TAG && b3[7:6] == CONT_TAG) begin
                    cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                    used = 4;
                end
                // Otherwise a malformed lead: one byte, code point is the byte
            end
            tone_code     = cp[20:0];
            tone_is_blank = b0 inside {CH_SPACE, CH_LF, CH_CR, CH_TAB};
            tone_len      = tone_is_blank ? 13'd0 : 13'(32'(set_rate) * set_char_ms / MS_PER_S);
            gap_len       = 11'(32'(set_rate) * set_gap_ms / MS_PER_S);
            total         = tone_len + gap_len;
            play_pos      = '0;
            // A blank token with no gap never starts playing
            play_on       = total > 0;
            r.accepted      = 1'b1;
            r.bytes_used    = 3'(used);
            r.code_point    = tone_code;
            r.token_samples = 13'(total);
            r.active        = play_on;
            n_tokens++;
            return r;
        end
        // Tick while idle gives an all-zero result
        if (!play_on)
            return r;
        if (!tone_is_blank && play_pos < tone_len) begin
            r.pcm_sample = buzz_sample(play_pos);
            n_tone++;
        end
        play_pos = play_pos + 13'd1;
        if (32'(play_pos) >= 32'(tone_len) + 32'(gap_len)) begin
            r.last   = 1'b1;
            play_on  = 1'b0;
            play_pos = '0;
        end
        r.active = play_on;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one command, hold it until taken, then log what it must produce
    task automatic send_item(input logic cmd, input logic [31:0] text);
        while (gaps_on && $urandom_range(0, 99) < 15) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.byte0   <= text[7:0];
        req_ch.byte1   <= text[15:8];
        req_ch.byte2   <= text[23:16];
        req_ch.byte3   <= text[31:24];
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        synth_out_due.push_back(predict_synth(cmd, text));
        n_sent++;
    endtask

    // Drop the request and wait until every owed result has been collected
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (synth_out_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // Write one register; the caller drops the write enable after the last one
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_SAMPLE_RATE:    set_rate    = 15'(clamp(data[14:0], RATE_MIN, RATE_MAX));
            CFG_PEAK_AMPLITUDE: set_amp     = 14'(clamp(data[13:0], AMP_MIN, AMP_MAX));
            CFG_CHAR_TIME_MS:   set_char_ms = 8'(clamp(data[7:0], CHAR_MIN, CHAR_MAX));
            CFG_GAP_TIME_MS:    set_gap_ms  = 7'(clamp(data[6:0], 0, GAP_MAX));
            default: ;
        endcase
    endtask

    // Bring the block to rest, then load all four settings (raw values)
    task automatic write_settings(input logic [CFG_DATA_W-1:0] rate,
                                  input logic [CFG_DATA_W-1:0] amp,
                                  input logic [CFG_DATA_W-1:0] char_ms,
                                  input logic [CFG_DATA_W-1:0] gap_ms);
        wait_drained();
        write_register(CFG_SAMPLE_RATE, rate);
        write_register(CFG_PEAK_AMPLITUDE, amp);
        write_register(CFG_CHAR_TIME_MS, char_ms);
        write_register(CFG_GAP_TIME_MS, gap_ms);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Tick until the token in play has given its final sample
    task automatic play_out();
        while (play_on)
            send_item(CMD_TICK, $urandom());
    endtask

    // Four text bytes, byte0 in the low byte: a random token of a random kind
    function automatic logic [31:0] random_text(input int blank_pct);
        logic [7:0] lead;
        logic [7:0] tail [1:3];
        int k;
        for (k = 1; k <= 3; k++)
            tail[k] = 8'h80 | 8'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < blank_pct) begin
            case ($urandom_range(0, 3))
                0:       lead = CH_SPACE;
                1:       lead = CH_TAB;
                2:       lead = CH_LF;
                default: lead = CH_CR;
            endcase
            return {8'($urandom()), 8'($urandom()), 8'($urandom()), lead};
        end
        case ($urandom_range(0, 5))
            0: begin
                // plain ASCII, control characters included
                lead = 8'($urandom_range(1, 127));
                for (k = 1; k <= 3; k++)
                    tail[k] = 8'($urandom());
            end
            1: lead = LEAD2_CODE | 8'($urandom_range(0, 31));
            2: lead = LEAD3_CODE | 8'($urandom_range(0, 15));
            3: lead = LEAD4_CODE | 8'($urandom_range(0, 7));
            4: begin
                // any high byte over random bytes: mostly malformed
                lead = 8'($urandom_range(128, 255));
                for (k = 1; k <= 3; k++)
                    tail[k] = 8'($urandom());
            end
            default: begin
                // proper lead with one continuation byte broken
                lead = 8'($urandom_range(8'hC0, 8'hF7));
                k = $urandom_range(1, 3);
                tail[k] = 8'($urandom());
                if (tail[k][7:6] == CONT_TAG)
                    tail[k][6] = 1'b1;
            end
        endcase
        return {tail[3], tail[2], tail[1], lead};
    endfunction

    // Text stream: a token, ticks until it ends, the next token, with some
    // noise (idle ticks, end-of-text bytes, characters offered while busy)
    task automatic run_text_stream(input int n_items, input int blank_pct);
        int roll;
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (play_on) begin
                if (roll < 8)
                    send_item(CMD_CHAR, random_text(blank_pct));
                else
                    send_item(CMD_TICK, $urandom());
            end
            else if (roll < 5)
                send_item(CMD_CHAR, $urandom() & 32'hFFFF_FF00);
            else if (roll < 12)
                send_item(CMD_TICK, $urandom());
            else
                send_item(CMD_CHAR, random_text(blank_pct));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Tick with nothing playing, and end-of-text characters at reset settings
    task automatic test_idle_and_end_of_text();
        send_item(CMD_TICK, 32'h0000_0000);
        send_item(CMD_CHAR, 32'hFFFF_FF00);
        send_item(CMD_CHAR, 32'h0000_0000);
        send_item(CMD_TICK, 32'hFFFF_FFFF);
    endtask

    // Zero raw settings saturate to the minima; blank tokens with no gap are
    // taken but never start playing
    task automatic test_whitespace_tokens();
        write_settings(15'd0, 15'd0, 15'd0, 15'd0);
        send_item(CMD_CHAR, {24'hFFFFFF, CH_SPACE});
        send_item(CMD_CHAR, {24'h000000, CH_TAB});
        send_item(CMD_CHAR, {24'hC3A980, CH_LF});
        send_item(CMD_CHAR, {24'h414243, CH_CR});
        send_item(CMD_TICK, $urandom());
    endtask

    // One full token with the largest code point, a refusal while busy, and a
    // settings change part way through the tone
    task automatic test_token_playout();
        write_settings(15'd8000, 15'd16000, 15'd20, 15'd1);
        send_item(CMD_CHAR, 32'hBFBF_BFF7);
        repeat (40) send_item(CMD_TICK, $urandom());
        send_item(CMD_CHAR, 32'h0000_A9C2);
        // lengths stay latched; phase and amplitude follow the new values
        wait_drained();
        write_register(CFG_PEAK_AMPLITUDE, 15'd512);
        write_register(CFG_SAMPLE_RATE, 15'd8400);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        play_out();
        // blank token with a short gap: silence only
        send_item(CMD_CHAR, {24'h414243, CH_CR});
        play_out();
        send_item(CMD_TICK, $urandom());
    endtask

    // Minimum settings, no idling on either side
    task automatic test_steady_stream();
        write_settings(15'd8000, 15'd512, 15'd20, 15'd0);
        gaps_on = 1'b0;
        run_text_stream(250, 30);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // Loud tone with a short gap after every token
    task automatic test_short_gap_stream();
        write_settings(15'd8000, 15'd16000, 15'd20, 15'd2);
        run_text_stream(250, 30);
    endtask

    // Fastest sample rate, saturated from an over-range raw value
    task automatic test_fast_rate_stream();
        write_settings(15'h7FFF, 15'($urandom_range(0, 32767)), 15'd20, 15'd0);
        run_text_stream(250, 25);
    endtask

    // Random settings; the receiver holds off long enough for the block to
    // back up, then the sender stops until everything owed has come back
    task automatic test_backpressure();
        write_settings(15'($urandom_range(7000, 11000)), 15'($urandom_range(0, 32767)),
                       15'($urandom_range(0, 24)), 15'($urandom_range(0, 4)));
        run_text_stream(100, 30);
        stall_request = 1'b1;
        run_text_stream(60, 30);
        wait_drained();
        run_text_stream(90, 30);
    endtask

    // Longest gap, many blank tokens: mostly silence
    task automatic test_long_gap_stream();
        write_settings(15'd8000, 15'd9000, 15'd20, 15'h7F);
        run_text_stream(250, 60);
    endtask

    // All settings saturated high: the longest token, reported and started
    task automatic test_longest_token();
        wait_drained();
        play_out();
        write_settings(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        send_item(CMD_CHAR, 32'h00BF_BFEF);
        repeat (24) send_item(CMD_TICK, $urandom());
        send_item(CMD_CHAR, {24'h000000, CH_SPACE});
        send_item(CMD_TICK, $urandom());
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready, one long hold-off on request, field checks
    // ------------------------------------------------------------------------
    function automatic void check_field(input string field, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            n_errors++;
        end
    endfunction

    initial
    begin : result_checker
        synth_out_t want;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                n_results++;
                if (synth_out_due.size() == 0) begin
                    $error("result with nothing outstanding");
                    n_errors++;
                end
                else begin
                    want = synth_out_due.pop_front();
                    check_field("accepted", want.accepted, rsp_ch.accepted);
                    check_field("bytes_used", want.bytes_used, rsp_ch.bytes_used);
                    check_field("code_point", want.code_point, rsp_ch.code_point);
                    check_field("token_samples", want.token_samples, rsp_ch.token_samples);
                    check_field("pcm_sample", $signed(want.pcm_sample), rsp_ch.pcm_sample);
                    check_field("last", want.last, rsp_ch.last);
                    check_field("active", want.active, rsp_ch.active);
                end
            end
            // Pick up a hold-off request and count it out here
            if (stall_request) begin
                stall_left    = HOLD_CYCLES;
                stall_request = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 15);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, synth_out_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Hold every input at a known value from the start
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= CFG_SAMPLE_RATE;
        cfg_wdata      <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_TICK;
        req_ch.byte0   <= 8'h00;
        req_ch.byte1   <= 8'h00;
        req_ch.byte2   <= 8'h00;
        req_ch.byte3   <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_end_of_text();
        test_whitespace_tokens();
        test_token_playout();
        test_steady_stream();
        test_short_gap_stream();
        test_fast_rate_stream();
        test_backpressure();
        test_long_gap_stream();
        test_longest_token();

        // Collect what is owed, then stay a while to catch stray results
        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (synth_out_due.size() != 0) begin
            $error("%0d results never arrived", synth_out_due.size());
            n_errors++;
        end

        $display("Commands sent %0d, results checked %0d, mismatches %0d",
                 n_sent, n_results, n_errors);
        $display("Tokens decoded %0d, commands refused %0d, tone samples %0d",
                 n_tokens, n_refused, n_tone);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
rtl/uctbs_pkg.sv
rtl/uctbs_if.sv
rtl/uctbs_cfg.sv
rtl/uctbs_decode.sv
rtl/uctbs_div.sv
rtl/utf8_character_buzz_tone_synth.sv
tb/sv/tb_utf8_character_buzz_tone_synth.sv
